// ----- hdl/lcgks_pkg.sv -----
package lcgks_pkg;

  // Generator and reseed constants
  localparam logic [31:0] LcgMul    = 32'd1103515245;
  localparam logic [31:0] LcgAdd    = 32'd12345;
  localparam logic [31:0] LcgMask   = 32'h7FFF_FFFF;
  localparam logic [31:0] ReseedMul = 32'd69069;
  localparam logic [31:0] ReseedAdd = 32'd1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgKeySeed   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDirection = 2'd1;

  // Direction codes
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // Header length in bytes
  localparam logic [2:0] HdrLen = 3'd4;

  // Results of one request handed to the output buffer
  typedef struct packed {
    logic        load;
    logic        hdr_en;
    logic [31:0] hdr_seed;
    logic [7:0]  data;
  } lcgks_load_t;

endpackage

// ----- hdl/lcg_keystream_byte_scrambler.sv -----
// Channel   Dir  Handshake                     Payload (low bit up)
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: data_byte[7:0]; tuser: first
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_byte[7:0]; tuser: is_header;
//                                              tlast: last
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One request is taken per cycle while the output buffer can load; its key step and
// reseed are done at the accepting edge and its results land in the output buffer.
// Encode requests marked first give five results (four header bytes, then data),
// so the input holds off while the buffer drains the header.
// Reset zeroes all but the buffer's byte registers; the config port is always ready.
// A stall on m_axis stops input once the output buffer holds a result not taken.
module lcg_keystream_byte_scrambler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // data_byte[7:0]
  input  logic                          s_axis_tuser,  // first
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // out_byte[7:0]
  output logic                          m_axis_tuser,  // is_header
  output logic                          m_axis_tlast,  // last
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lcgks_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import lcgks_pkg::*;

  logic [31:0] key_seed_q, key_seed_d;
  logic        dir_q, dir_d;
  logic [31:0] lcg_q, lcg_d;
  logic [31:0] nbs_q, nbs_d;
  logic [7:0]  pos_q, pos_d;
  logic [2:0]  hc_q, hc_d;

  logic        accept;
  logic        can_load;
  lcgks_load_t load;

  logic [31:0] lcg_base, nbs_base;
  logic [7:0]  pos_base;
  logic [31:0] lcg_prod, lcg_new, reseed;
  logic [7:0]  key;
  logic [7:0]  enc_mix, dec_mix;
  logic [31:0] nbs_hdr;
  logic [2:0]  hc_inc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // Register writes
  always_comb begin
    key_seed_d = key_seed_q;
    dir_d      = dir_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CfgKeySeed) begin
        key_seed_d = cfg_data_i;
      end else if (cfg_index_i == CfgDirection) begin
        dir_d = cfg_data_i[0];
      end
    end
  end

  // Select the generator start: key seed on an encode message start
  always_comb begin
    if (dir_q == DirEncode && s_axis_tuser) begin
      lcg_base = key_seed_q;
      nbs_base = key_seed_q;
      pos_base = 8'd0;
    end else begin
      lcg_base = lcg_q;
      nbs_base = nbs_q;
      pos_base = pos_q;
    end
  end

  // Advance the generator and prepare the block reseed in parallel
  assign lcg_prod = lcg_base * LcgMul;
  assign lcg_new  = (lcg_prod + LcgAdd) & LcgMask;
  assign reseed   = nbs_base * ReseedMul + ReseedAdd;
  assign key      = lcg_new[23:16];

  // Byte transforms
  always_comb begin
    logic [7:0] t;
    t       = s_axis_tdata ^ key;
    enc_mix = {t[4:0], t[7:5]} ^ pos_base;
    t       = s_axis_tdata ^ pos_base;
    dec_mix = {t[2:0], t[7:3]} ^ key;
  end

  // Decode header assembly, least significant byte first
  assign nbs_hdr = nbs_q | ({24'd0, s_axis_tdata} << {hc_q[1:0], 3'b000});
  assign hc_inc  = hc_q + 3'd1;

  // State update and result load
  always_comb begin
    lcg_d = lcg_q;
    nbs_d = nbs_q;
    pos_d = pos_q;
    hc_d  = hc_q;
    load.load     = 1'b0;
    load.hdr_en   = 1'b0;
    load.hdr_seed = key_seed_q;
    load.data     = enc_mix;
    if (accept) begin
      if (dir_q == DirEncode || (!s_axis_tuser && hc_q >= HdrLen)) begin
        // Data byte: emit, step the position, reseed at block end
        load.load   = 1'b1;
        load.hdr_en = (dir_q == DirEncode) && s_axis_tuser;
        load.data   = (dir_q == DirEncode) ? enc_mix : dec_mix;
        pos_d       = pos_base + 8'd1;
        if (pos_base == 8'hFF) begin
          nbs_d = reseed;
          lcg_d = reseed;
        end else begin
          nbs_d = nbs_base;
          lcg_d = lcg_new;
        end
        if (dir_q == DirEncode && s_axis_tuser) begin
          hc_d = HdrLen;
        end
      end else if (s_axis_tuser) begin
        // Decode message start: first header byte
        nbs_d = {24'd0, s_axis_tdata};
        hc_d  = 3'd1;
      end else begin
        // Decode header byte, start the generator once complete
        nbs_d = nbs_hdr;
        hc_d  = hc_inc;
        if (hc_inc == HdrLen) begin
          lcg_d = nbs_hdr;
          pos_d = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_seed_q <= 32'd0;
      dir_q      <= DirEncode;
      lcg_q      <= 32'd0;
      nbs_q      <= 32'd0;
      pos_q      <= 8'd0;
      hc_q       <= 3'd0;
    end else begin
      key_seed_q <= key_seed_d;
      dir_q      <= dir_d;
      lcg_q      <= lcg_d;
      nbs_q      <= nbs_d;
      pos_q      <= pos_d;
      hc_q       <= hc_d;
    end
  end

  lcgks_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- hdl/lcgks_out_buf.sv -----
module lcgks_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcgks_pkg::lcgks_load_t load_i,
  output logic                  can_load_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,  // out_byte[7:0]
  output logic                  m_axis_tuser,  // is_header
  output logic                  m_axis_tlast   // last
);
  import lcgks_pkg::*;

  logic [2:0]  hdr_left_q, hdr_left_d;
  logic        data_pend_q, data_pend_d;
  logic [31:0] hdr_q, hdr_d;
  logic [7:0]  data_q, data_d;
  logic        hdr_busy;
  logic        pop;

  assign hdr_busy      = (hdr_left_q != 3'd0);
  assign m_axis_tvalid = hdr_busy | data_pend_q;
  assign m_axis_tdata  = hdr_busy ? hdr_q[7:0] : data_q;
  assign m_axis_tuser  = hdr_busy;
  assign m_axis_tlast  = ~hdr_busy;
  assign pop           = m_axis_tvalid & m_axis_tready;

  // Take a new load when empty or when the data beat leaves this cycle
  assign can_load_o = ~m_axis_tvalid | (m_axis_tready & ~hdr_busy);

  // Load results, or drain header bytes low byte first, then the data byte
  always_comb begin
    hdr_left_d  = hdr_left_q;
    data_pend_d = data_pend_q;
    hdr_d       = hdr_q;
    data_d      = data_q;
    if (load_i.load) begin
      hdr_left_d  = load_i.hdr_en ? HdrLen : 3'd0;
      data_pend_d = 1'b1;
      hdr_d       = load_i.hdr_seed;
      data_d      = load_i.data;
    end else if (pop) begin
      if (hdr_busy) begin
        hdr_left_d = hdr_left_q - 3'd1;
        hdr_d      = {8'd0, hdr_q[31:8]};
      end else begin
        data_pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_left_q  <= 3'd0;
      data_pend_q <= 1'b0;
    end else begin
      hdr_left_q  <= hdr_left_d;
      data_pend_q <= data_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q  <= hdr_d;
    data_q <= data_d;
  end

endmodule
